[hdl/matrix_projection_profile_normalizer_top_defines.svh]
// assertion macros for the projection profile normalizer top level
// expects aclk and aresetn in the scope of each use
`ifndef MATRIX_PROJECTION_PROFILE_NORMALIZER_TOP_DEFINES_SVH
`define MATRIX_PROJECTION_PROFILE_NORMALIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MPP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPP_ASSERT_SAME(lbl, ante, cons, msg)
`define MPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/mpp_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and helpers of the projection profile normalizer
// no dependencies
package mpp_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    // both profile stores share one depth
    localparam int STORE_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int AW          = $clog2(STORE_DEPTH);

    localparam int SUM_W   = 32;
    localparam int SMP_W   = 16;
    localparam int BOUND_W = 7;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 17;
    localparam int QBITS   = 17;           // quotient bits before rounding
    localparam int CNT_W   = $clog2(QBITS + 1);

    localparam logic [BOUND_W-1:0] MAX_ROWS_B = BOUND_W'(MAX_ROWS);
    localparam logic [BOUND_W-1:0] MAX_COLS_B = BOUND_W'(MAX_COLS);
    localparam logic [VAL_W-1:0]   ONE_Q16    = VAL_W'(65536);

    typedef enum logic [2:0] {
        REG_COL_LO         = 3'd0,
        REG_COL_HI         = 3'd1,
        REG_ROW_LO         = 3'd2,
        REG_ROW_HI         = 3'd3,
        REG_ROW_COUNT      = 3'd4,
        REG_ROW_PROFILE_ON = 3'd5,
        REG_COL_PROFILE_ON = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef enum logic {
        SEL_ROW = 1'b0,
        SEL_COL = 1'b1
    } prof_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_SCAN_END,
        ST_RD_WAIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    // one access cycle of a sum store
    typedef struct packed {
        logic                    clr;
        logic                    wr_en;
        logic [AW-1:0]           wr_addr;
        logic signed [SUM_W-1:0] wr_data;
        logic [AW-1:0]           rd_addr;
    } store_cmd_t;

    function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] v,
                                                       input logic [BOUND_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

[hdl/mpp_sum_store.sv]
`timescale 1ns / 1ps
// one profile sum memory, one write and one registered read per cycle
// entries carry valid bits so a frame clear resets them all together; uses mpp_pkg
module mpp_sum_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mpp_pkg::store_cmd_t             cmd,
    output logic signed [mpp_pkg::SUM_W-1:0] rd_data
);

    logic signed [mpp_pkg::SUM_W-1:0] mem [mpp_pkg::STORE_DEPTH];
    logic [mpp_pkg::STORE_DEPTH-1:0]  valid_reg;
    logic [mpp_pkg::STORE_DEPTH-1:0]  valid_next;
    logic signed [mpp_pkg::SUM_W-1:0] rd_data_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        rd_data_reg <= mem[cmd.rd_addr];
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clr) begin
            valid_next = '0;
        end else if (cmd.wr_en) begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            // a clear in the read cycle makes the entry read as zero
            rd_valid_reg <= valid_reg[cmd.rd_addr] & ~cmd.clr;
        end
    end

    // entries never written since reset or frame start read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hdl/mpp_divider.sv]
`timescale 1ns / 1ps
// bit-serial restoring divider for num * 2^16 / den, rounded half up
// one quotient bit per cycle; num < den required; uses mpp_pkg
module mpp_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mpp_pkg::SUM_W-1:0]   num,
    input  logic [mpp_pkg::SUM_W-1:0]   den,
    output logic                        done,
    output logic [mpp_pkg::VAL_W-1:0]   quo
);

    logic [mpp_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [mpp_pkg::SUM_W-1:0] den_reg, den_next;
    logic [mpp_pkg::QBITS-1:0] q_reg, q_next;
    logic [mpp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [mpp_pkg::SUM_W:0]   trial;
    logic                      qbit;
    logic [mpp_pkg::QBITS:0]   rounded;

    always_comb begin
        trial     = {rem_reg, 1'b0};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
            cnt_next  = mpp_pkg::CNT_W'(mpp_pkg::QBITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? mpp_pkg::SUM_W'(trial - {1'b0, den_reg})
                            : mpp_pkg::SUM_W'(trial);
            q_next   = {q_reg[mpp_pkg::QBITS-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mpp_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // q holds floor(2x); floor(2x + 1) / 2 rounds x half up
    assign rounded = {1'b0, q_reg} + (mpp_pkg::QBITS+1)'(1);
    assign quo     = rounded[mpp_pkg::QBITS:1];
    assign done    = done_reg;

endmodule

[hdl/matrix_projection_profile_normalizer_top.sv]
`timescale 1ns / 1ps
// row and column projection profiles with min-max normalized reads
// uses mpp_pkg, mpp_sum_store, mpp_divider and the assertion macro header
//
//  channel   direction  payload                                     request when
//  s_*       in         tdata {entry_index, sample}, tlast, tuser   s_tvalid & s_tready
//  m_*       out        tdata {profile_value}, tuser {out_of_range} m_tvalid & m_tready
//  cfg_*     in         index / 7-bit data, write only              cfg_wr_en
//
// a sample is a store read, then add and write back on the same port
// a sample marked last adds a min/max scan over both stores
// a read is a store read and a compare, plus the serial divider when it normalizes
// a finished result waits in the output register; sample requests still go on
// aresetn is synchronous; sum stores read as zero after reset through valid bits
`include "matrix_projection_profile_normalizer_top_defines.svh"

module matrix_projection_profile_normalizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] sample, [21:16] entry_index, [23:22] zero
    input  logic        s_tlast,   // last_sample
    input  logic [1:0]  s_tuser,   // [0] func, [1] profile_select
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] profile_value, [23:17] zero
    output logic        m_tuser,   // [0] out_of_range
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    localparam int AW  = mpp_pkg::AW;
    localparam int BW  = mpp_pkg::BOUND_W;
    localparam int SW  = mpp_pkg::SUM_W;
    localparam int VW  = mpp_pkg::VAL_W;

    // ---------------- configuration registers ----------------
    logic [BW-1:0] col_lo_reg, col_hi_reg, row_lo_reg, row_hi_reg, row_count_reg;
    logic          row_on_reg, col_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_lo_reg    <= '0;
            col_hi_reg    <= mpp_pkg::MAX_COLS_B;
            row_lo_reg    <= '0;
            row_hi_reg    <= mpp_pkg::MAX_ROWS_B;
            row_count_reg <= mpp_pkg::MAX_ROWS_B;
            row_on_reg    <= 1'b1;
            col_on_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            case (mpp_pkg::cfg_reg_t'(cfg_index))
                mpp_pkg::REG_COL_LO:         col_lo_reg    <= cfg_wdata;
                mpp_pkg::REG_COL_HI:         col_hi_reg    <= cfg_wdata;
                mpp_pkg::REG_ROW_LO:         row_lo_reg    <= cfg_wdata;
                mpp_pkg::REG_ROW_HI:         row_hi_reg    <= cfg_wdata;
                mpp_pkg::REG_ROW_COUNT:      row_count_reg <= cfg_wdata;
                mpp_pkg::REG_ROW_PROFILE_ON: row_on_reg    <= cfg_wdata[0];
                mpp_pkg::REG_COL_PROFILE_ON: col_on_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // window bounds clamped to the store depth
    logic [BW-1:0] clo, chi, rlo, rhi, rc;
    assign clo = mpp_pkg::clamp_bound(col_lo_reg, mpp_pkg::MAX_COLS_B);
    assign chi = mpp_pkg::clamp_bound(col_hi_reg, mpp_pkg::MAX_COLS_B);
    assign rlo = mpp_pkg::clamp_bound(row_lo_reg, mpp_pkg::MAX_ROWS_B);
    assign rhi = mpp_pkg::clamp_bound(row_hi_reg, mpp_pkg::MAX_ROWS_B);

    always_comb begin
        rc = mpp_pkg::clamp_bound(row_count_reg, mpp_pkg::MAX_ROWS_B);
        if (rc == '0) begin
            rc = BW'(1);
        end
    end

    // ---------------- input fields ----------------
    logic                             in_func;
    logic                             in_sel;
    logic signed [mpp_pkg::SMP_W-1:0] in_sample;
    logic [mpp_pkg::IDX_W-1:0]        in_index;
    logic                             in_accept;

    assign in_func   = s_tuser[0];
    assign in_sel    = s_tuser[1];
    assign in_sample = s_tdata[15:0];
    assign in_index  = s_tdata[21:16];
    assign in_accept = s_tvalid & s_tready;

    // ---------------- state ----------------
    mpp_pkg::state_t state_reg, state_next;

    logic [AW-1:0] row_pos_reg, row_pos_next;
    logic [BW-1:0] col_pos_reg, col_pos_next;
    logic          frame_done_reg, frame_done_next;

    logic signed [SW-1:0] row_min_reg, row_min_next, row_max_reg, row_max_next;
    logic signed [SW-1:0] col_min_reg, col_min_next, col_max_reg, col_max_next;
    logic                 row_seen_reg, row_seen_next, col_seen_reg, col_seen_next;

    logic [AW-1:0] scan_k_reg, scan_k_next;
    logic [AW-1:0] scan_d_reg, scan_d_next;
    logic          scan_pend_reg, scan_pend_next;

    // request payload held over the access
    logic signed [mpp_pkg::SMP_W-1:0] smp_reg, smp_next;
    logic                             last_reg, last_next;
    logic                             wr_row_reg, wr_row_next, wr_col_reg, wr_col_next;
    logic [AW-1:0]                    row_addr_reg, row_addr_next;
    logic [AW-1:0]                    col_addr_reg, col_addr_next;
    logic                             sel_reg, sel_next;
    logic                             oor_reg, oor_next;

    // pending and presented result
    logic [VW-1:0] res_val_reg, res_val_next;
    logic          res_oor_reg, res_oor_next;
    logic          m_valid_reg, m_valid_next;
    logic [VW-1:0] m_val_reg, m_val_next;
    logic          m_oor_reg, m_oor_next;

    // ---------------- stores and divider ----------------
    mpp_pkg::store_cmd_t  row_cmd, col_cmd;
    logic signed [SW-1:0] row_rd, col_rd;

    mpp_sum_store u_row_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (row_cmd),
        .rd_data (row_rd)
    );

    mpp_sum_store u_col_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (col_cmd),
        .rd_data (col_rd)
    );

    logic          div_start;
    logic [SW-1:0] div_num, div_den;
    logic          div_done;
    logic [VW-1:0] div_quo;

    mpp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------- request decode ----------------
    logic          smp_in_win;
    logic [BW-1:0] rd_lo, rd_hi, rd_len, rd_pos;
    logic          rd_on, rd_ok;
    logic [BW:0]   row_pos_inc;

    always_comb begin
        smp_in_win = ({1'b0, row_pos_reg} >= rlo) && ({1'b0, row_pos_reg} < rhi) &&
                     (col_pos_reg < mpp_pkg::MAX_COLS_B) &&
                     (col_pos_reg >= clo) && (col_pos_reg < chi);
        row_pos_inc = {2'b0, row_pos_reg} + (BW+1)'(1);

        rd_lo  = (in_sel == mpp_pkg::SEL_COL) ? clo : rlo;
        rd_hi  = (in_sel == mpp_pkg::SEL_COL) ? chi : rhi;
        rd_on  = (in_sel == mpp_pkg::SEL_COL) ? col_on_reg : row_on_reg;
        rd_len = (rd_hi > rd_lo) ? BW'(rd_hi - rd_lo) : '0;
        rd_ok  = rd_on && ({1'b0, in_index} < rd_len);
        rd_pos = BW'(rd_lo + {1'b0, in_index});
    end

    // ---------------- scan and read-back datapath ----------------
    logic                 scan_row_in, scan_col_in;
    logic signed [SW-1:0] sel_v, sel_mn, sel_mx;
    logic signed [SW:0]   diff_num, diff_den;

    always_comb begin
        scan_row_in = ({1'b0, scan_d_reg} >= rlo) && ({1'b0, scan_d_reg} < rhi);
        scan_col_in = ({1'b0, scan_d_reg} >= clo) && ({1'b0, scan_d_reg} < chi);

        sel_v    = (sel_reg == mpp_pkg::SEL_COL) ? col_rd      : row_rd;
        sel_mn   = (sel_reg == mpp_pkg::SEL_COL) ? col_min_reg : row_min_reg;
        sel_mx   = (sel_reg == mpp_pkg::SEL_COL) ? col_max_reg : row_max_reg;
        diff_num = (SW+1)'(sel_v) - (SW+1)'(sel_mn);
        diff_den = (SW+1)'(sel_mx) - (SW+1)'(sel_mn);
        div_num  = diff_num[SW-1:0];
        div_den  = diff_den[SW-1:0];
    end

    // ---------------- control ----------------
    logic out_free;
    assign out_free = ~m_valid_reg | m_tready;

    always_comb begin
        state_next      = state_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        frame_done_next = frame_done_reg;
        row_min_next    = row_min_reg;
        row_max_next    = row_max_reg;
        col_min_next    = col_min_reg;
        col_max_next    = col_max_reg;
        row_seen_next   = row_seen_reg;
        col_seen_next   = col_seen_reg;
        scan_k_next     = scan_k_reg;
        scan_d_next     = scan_k_reg;
        scan_pend_next  = 1'b0;
        smp_next        = smp_reg;
        last_next       = last_reg;
        wr_row_next     = wr_row_reg;
        wr_col_next     = wr_col_reg;
        row_addr_next   = row_addr_reg;
        col_addr_next   = col_addr_reg;
        sel_next        = sel_reg;
        oor_next        = oor_reg;
        res_val_next    = res_val_reg;
        res_oor_next    = res_oor_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_val_next      = m_val_reg;
        m_oor_next      = m_oor_reg;
        div_start       = 1'b0;
        s_tready        = 1'b0;

        // default store access: read at the current matrix position
        row_cmd         = '0;
        col_cmd         = '0;
        row_cmd.rd_addr = row_pos_reg;
        col_cmd.rd_addr = col_pos_reg[AW-1:0];
        row_cmd.wr_addr = row_addr_reg;
        col_cmd.wr_addr = col_addr_reg;
        row_cmd.wr_data = row_rd + SW'(smp_reg);
        col_cmd.wr_data = col_rd + SW'(smp_reg);

        case (state_reg)
            mpp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (in_func == mpp_pkg::FUNC_READ) begin
                    row_cmd.rd_addr = rd_pos[AW-1:0];
                    col_cmd.rd_addr = rd_pos[AW-1:0];
                end
                if (in_accept) begin
                    if (in_func == mpp_pkg::FUNC_SAMPLE) begin
                        // first sample of a new frame wipes both stores
                        row_cmd.clr     = frame_done_reg;
                        col_cmd.clr     = frame_done_reg;
                        frame_done_next = 1'b0;
                        smp_next        = in_sample;
                        last_next       = s_tlast;
                        wr_row_next     = smp_in_win & row_on_reg;
                        wr_col_next     = smp_in_win & col_on_reg;
                        row_addr_next   = row_pos_reg;
                        col_addr_next   = col_pos_reg[AW-1:0];
                        if (row_pos_inc >= {1'b0, rc}) begin
                            row_pos_next = '0;
                            if (col_pos_reg < mpp_pkg::MAX_COLS_B) begin
                                col_pos_next = col_pos_reg + 1'b1;
                            end
                        end else begin
                            row_pos_next = row_pos_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            row_pos_next = '0;
                            col_pos_next = '0;
                        end
                        state_next = mpp_pkg::ST_ADD;
                    end else begin
                        sel_next   = in_sel;
                        oor_next   = ~rd_ok;
                        state_next = mpp_pkg::ST_RD_WAIT;
                    end
                end
            end

            mpp_pkg::ST_ADD: begin
                row_cmd.wr_en = wr_row_reg;
                col_cmd.wr_en = wr_col_reg;
                if (last_reg) begin
                    frame_done_next = 1'b1;
                    row_min_next    = '0;
                    row_max_next    = '0;
                    col_min_next    = '0;
                    col_max_next    = '0;
                    row_seen_next   = 1'b0;
                    col_seen_next   = 1'b0;
                    scan_k_next     = '0;
                    state_next      = mpp_pkg::ST_SCAN;
                end else begin
                    state_next = mpp_pkg::ST_IDLE;
                end
            end

            mpp_pkg::ST_SCAN, mpp_pkg::ST_SCAN_END: begin
                row_cmd.rd_addr = scan_k_reg;
                col_cmd.rd_addr = scan_k_reg;
                if (state_reg == mpp_pkg::ST_SCAN) begin
                    scan_pend_next = 1'b1;
                    scan_k_next    = scan_k_reg + 1'b1;
                    if (scan_k_reg == AW'(mpp_pkg::STORE_DEPTH - 1)) begin
                        state_next = mpp_pkg::ST_SCAN_END;
                    end
                end else begin
                    state_next = mpp_pkg::ST_IDLE;
                end
                // fold in the entry read in the previous scan cycle
                if (scan_pend_reg) begin
                    if (scan_row_in) begin
                        row_seen_next = 1'b1;
                        if (!row_seen_reg || row_rd < row_min_reg) row_min_next = row_rd;
                        if (!row_seen_reg || row_rd > row_max_reg) row_max_next = row_rd;
                    end
                    if (scan_col_in) begin
                        col_seen_next = 1'b1;
                        if (!col_seen_reg || col_rd < col_min_reg) col_min_next = col_rd;
                        if (!col_seen_reg || col_rd > col_max_reg) col_max_next = col_rd;
                    end
                end
            end

            mpp_pkg::ST_RD_WAIT: begin
                res_oor_next = oor_reg;
                state_next   = mpp_pkg::ST_EMIT;
                if (oor_reg) begin
                    res_val_next = '0;
                end else if (sel_mx <= sel_mn) begin
                    // flat profile
                    res_val_next = mpp_pkg::ONE_Q16;
                end else if (sel_v <= sel_mn) begin
                    res_val_next = '0;
                end else if (sel_v >= sel_mx) begin
                    res_val_next = mpp_pkg::ONE_Q16;
                end else begin
                    div_start  = 1'b1;
                    state_next = mpp_pkg::ST_DIV;
                end
            end

            mpp_pkg::ST_DIV: begin
                if (div_done) begin
                    res_val_next = div_quo;
                    state_next   = mpp_pkg::ST_EMIT;
                end
            end

            mpp_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_oor_next   = res_oor_reg;
                    state_next   = mpp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mpp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mpp_pkg::ST_IDLE;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            frame_done_reg <= 1'b0;
            row_min_reg    <= '0;
            row_max_reg    <= '0;
            col_min_reg    <= '0;
            col_max_reg    <= '0;
            row_seen_reg   <= 1'b0;
            col_seen_reg   <= 1'b0;
            scan_k_reg     <= '0;
            scan_pend_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            frame_done_reg <= frame_done_next;
            row_min_reg    <= row_min_next;
            row_max_reg    <= row_max_next;
            col_min_reg    <= col_min_next;
            col_max_reg    <= col_max_next;
            row_seen_reg   <= row_seen_next;
            col_seen_reg   <= col_seen_next;
            scan_k_reg     <= scan_k_next;
            scan_pend_reg  <= scan_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_d_reg   <= scan_d_next;
        smp_reg      <= smp_next;
        last_reg     <= last_next;
        wr_row_reg   <= wr_row_next;
        wr_col_reg   <= wr_col_next;
        row_addr_reg <= row_addr_next;
        col_addr_reg <= col_addr_next;
        sel_reg      <= sel_next;
        oor_reg      <= oor_next;
        res_val_reg  <= res_val_next;
        res_oor_reg  <= res_oor_next;
        m_val_reg    <= m_val_next;
        m_oor_reg    <= m_oor_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(24 - VW)'(0), m_val_reg};
    assign m_tuser  = m_oor_reg;

    // ---------------- checks ----------------
    `MPP_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == mpp_pkg::ST_DIV, "divider finished outside its wait state")
    `MPP_ASSERT_SAME(a_result_in_range, m_valid_reg, m_val_reg <= mpp_pkg::ONE_Q16, "normalized value above one")
    `MPP_ASSERT_SAME(a_oor_reads_zero, m_valid_reg && m_oor_reg, m_val_reg == '0, "out of range result carries a value")
    `MPP_ASSERT_NEXT(a_sample_goes_add, in_accept && (in_func == mpp_pkg::FUNC_SAMPLE), state_reg == mpp_pkg::ST_ADD, "sample request did not reach the add cycle")

endmodule
